// ===== hdl/dwr_pkg.sv =====
// ----------------------------------------------------------------------------
// dwr_pkg
// Shared constants, codes and controller/datapath interface types for the
// double-ended queue with reverse.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package dwr_pkg;

  localparam int DEPTH = 1024;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW    = $clog2(DEPTH + 1);
  localparam int SW    = CW + 1;
  localparam int DW    = 32;

  localparam logic [2:0] ACT_PUSH_BACK  = 3'd0;
  localparam logic [2:0] ACT_PUSH_FRONT = 3'd1;
  localparam logic [2:0] ACT_POP_BACK   = 3'd2;
  localparam logic [2:0] ACT_POP_FRONT  = 3'd3;
  localparam logic [2:0] ACT_REVERSE    = 3'd4;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  typedef struct packed {
    logic load;
    logic exec;
    logic emit_err;
    logic emit_pop;
  } dwr_cmd_t;

  typedef struct packed {
    logic err;
    logic pop_ok;
    logic empty;
    logic full;
  } dwr_stat_t;

endpackage

`default_nettype wire

// ===== hdl/dwr_ctrl.sv =====
// ----------------------------------------------------------------------------
// dwr_ctrl
// Controller: sequences load, execute and memory read of one item and
// schedules the result strobe.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module dwr_ctrl
  import dwr_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      start,
  output logic           busy,
  input  dwr_stat_t      stat,
  output dwr_cmd_t       cmd
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_EXEC = 3'b010,
    S_POP  = 3'b100
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next   = state;
    cmd          = '0;
    busy         = 1'b1;
    unique case (state)
      S_IDLE: begin
        busy = 1'b0;
        if (start) begin
          cmd.load   = 1'b1;
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd.exec = 1'b1;
        if (stat.err) begin
          cmd.emit_err = 1'b1;
          state_next   = S_IDLE;
        end else if (stat.pop_ok) begin
          state_next = S_POP;
        end else begin
          state_next = S_IDLE;
        end
      end
      S_POP: begin
        cmd.emit_pop = 1'b1;
        state_next   = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== hdl/dwr_dp.sv =====
// ----------------------------------------------------------------------------
// dwr_dp
// Datapath: item register, ring store, head pointer, entry count,
// orientation flag and result registers.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module dwr_dp
  import dwr_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic [2:0]           action,
  input  wire logic signed [DW-1:0] push_value,
  input  dwr_cmd_t                  cmd,
  output dwr_stat_t                 stat,
  output logic                      done,
  output logic signed [DW-1:0]      pop_value,
  output logic [1:0]                status
);

  logic [DW-1:0] mem [DEPTH];
  logic [DW-1:0] rdata;

  logic [2:0]    act_q;
  logic [DW-1:0] val_q;

  logic [AW-1:0] head;
  logic [CW-1:0] count;
  logic          reversed;

  logic          is_pop;
  logic          is_rev;
  logic          is_front;
  logic          left;
  logic          empty;
  logic          full;
  logic [SW-1:0] base;
  logic [SW-1:0] tail_raw;
  logic [AW-1:0] tail_addr;
  logic [AW-1:0] head_dec;
  logic [AW-1:0] head_inc;
  logic [AW-1:0] addr;
  logic          do_push;
  logic          do_pop;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      act_q <= action;
      val_q <= push_value;
    end
  end

  always_comb begin
    is_pop   = (act_q == ACT_POP_BACK) || (act_q == ACT_POP_FRONT);
    is_rev   = (act_q == ACT_REVERSE);
    is_front = is_pop ? (act_q == ACT_POP_FRONT) : (act_q != ACT_PUSH_BACK);
    left     = is_front ^ reversed;
    empty    = (count == '0);
    full     = (count == CW'(DEPTH));

    base     = SW'(head) + SW'(count);
    tail_raw = is_pop ? base - SW'(1) : base;
    tail_addr = (tail_raw >= SW'(DEPTH)) ? AW'(tail_raw - SW'(DEPTH)) : AW'(tail_raw);
    head_dec = (head == '0) ? AW'(DEPTH - 1) : head - AW'(1);
    head_inc = (head == AW'(DEPTH - 1)) ? '0 : head + AW'(1);

    if (left) begin
      addr = is_pop ? head : head_dec;
    end else begin
      addr = tail_addr;
    end

    do_push = cmd.exec && !is_pop && !is_rev && !full;
    do_pop  = cmd.exec && is_pop && !empty;

    stat.err    = (is_pop && empty) || (!is_pop && !is_rev && full);
    stat.pop_ok = is_pop && !empty;
    stat.empty  = empty;
    stat.full   = full;
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[addr] <= val_q;
    end
    if (do_pop) begin
      rdata <= mem[addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head     <= '0;
      count    <= '0;
      reversed <= 1'b0;
    end else if (cmd.exec) begin
      if (is_rev) begin
        reversed <= !reversed;
      end else if (do_push) begin
        count <= count + CW'(1);
        if (left) begin
          head <= head_dec;
        end
      end else if (do_pop) begin
        count <= count - CW'(1);
        if (left) begin
          head <= head_inc;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= cmd.emit_err || cmd.emit_pop;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_err) begin
      pop_value <= '0;
      status    <= is_pop ? ST_EMPTY : ST_FULL;
    end else if (cmd.emit_pop) begin
      pop_value <= rdata;
      status    <= ST_OK;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/deque_with_reverse_unit.sv =====
// ----------------------------------------------------------------------------
// deque_with_reverse_unit
// Double-ended queue of signed 32-bit values in a ring store, with push and
// pop at either end and a one-step reverse.
// ----------------------------------------------------------------------------
// busy covers EXEC after accept, and POP as well for a pop that succeeds;
// error results strobe done from EXEC, pop results from POP (registered store read)
// a new item is taken only when idle; a push or reverse that succeeds gives no strobe
// done is a single-cycle strobe; the receiver cannot stall it
// reset clears head, count and orientation; store contents are not cleared
`timescale 1ns / 1ps
`default_nettype none

module deque_with_reverse_unit
  import dwr_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 start,
  input  wire logic [2:0]           action,
  input  wire logic signed [DW-1:0] push_value,
  output logic                      busy,
  output logic                      done,
  output logic signed [DW-1:0]      pop_value,
  output logic [1:0]                status
);

  dwr_cmd_t  cmd;
  dwr_stat_t stat;

  dwr_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .stat  (stat),
    .cmd   (cmd)
  );

  dwr_dp u_dp (
    .clk        (clk),
    .rst        (rst),
    .action     (action),
    .push_value (push_value),
    .cmd        (cmd),
    .stat       (stat),
    .done       (done),
    .pop_value  (pop_value),
    .status     (status)
  );

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy)
    else $error("busy not raised after accept");

  a_done_pulse: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("result strobe longer than one cycle");

  a_pop_after_exec: assert property (@(posedge clk) disable iff (rst)
    cmd.emit_pop |-> $past(cmd.exec) && $past(stat.pop_ok))
    else $error("pop result without executed pop");

  a_empty_full: assert property (@(posedge clk) disable iff (rst)
    !(stat.empty && stat.full))
    else $error("queue both empty and full");

endmodule

`default_nettype wire
